### rtl/core/bscn_pkg.sv
// shared constants, request codes and helpers for the circular bitmap block
`default_nettype none

package bscn_pkg;

   localparam int CAPACITY_DEF = 512;
   localparam int WORD_BITS    = 64;
   localparam int BIT_W        = 6;
   localparam int INDEX_W      = 10;
   localparam int POS_OUT_W    = 9;
   localparam int REQ_TDATA_W  = 16;
   localparam int RSP_TDATA_W  = 16;

   typedef enum logic [1:0] {
      REQ_ADD   = 2'd0,
      REQ_QUERY = 2'd1,
      REQ_NEXT  = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   // position of the lowest set bit, zero when the word is empty
   function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
      logic [BIT_W-1:0] r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = BIT_W'(i);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/bitmap_set_circular_next.sv
// circular membership bitmap with add, query and find-next-set over a word memory
// add and query read the indexed word, then register the result; next reads word after word until a hit or wrap
// throughput: one beat at a time; next walks the bitmap memory one 64-bit word per cycle,
//   so up to WORDS+1 reads (9 at the default capacity of 512)
// reset: synchronous; per-word valid flags mark the memory empty at once, position goes to 0
// an input beat is taken while an earlier result still waits in the output register
`default_nettype none

module bitmap_set_circular_next
   import bscn_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // [9:0] index, rest zero
   input  wire logic [1:0]             req_tuser,  // [1:0] req_type
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata   // [0] present, [9:1] position, rest zero
);

   localparam int WORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
   localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int FW    = WAW + BIT_W;
   localparam int PW    = $clog2(CAPACITY);
   localparam int CW    = $clog2(WORDS + 1);
   localparam logic [CW-1:0]  LAST_STEP = CW'(WORDS);
   localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ACC,
      S_SCAN
   } state_type;

   state_type              state_ff, state_in;
   req_kind_type           kind_ff, kind_in;
   logic [INDEX_W-1:0]     idx_ff, idx_in;
   logic [PW-1:0]          cur_ff, cur_in;
   logic [WAW-1:0]         scan_word_ff, scan_word_in;
   logic [CW-1:0]          scan_cnt_ff, scan_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_present_ff, rsp_present_in;
   logic [POS_OUT_W-1:0]   rsp_pos_ff, rsp_pos_in;

   logic [WORD_BITS-1:0]   mem [WORDS];
   logic [WORDS-1:0]       wvalid_ff;
   logic [WORD_BITS-1:0]   rd_data_ff;
   logic                   rd_valid_ff;

   logic                   rd_en;
   logic [WAW-1:0]         rd_addr;
   logic                   wr_en;
   logic [WAW-1:0]         wr_addr;
   logic [WORD_BITS-1:0]   wr_data;

   logic                   out_free;
   logic [WORD_BITS-1:0]   word;
   logic [FW-1:0]          cur_full;
   logic [FW-1:0]          idx_full;
   logic [FW-1:0]          req_full;
   logic                   idx_in_range;
   logic                   req_in_range;
   logic [WORD_BITS-1:0]   le_mask;
   logic [WORD_BITS-1:0]   scan_mask;
   logic [WORD_BITS-1:0]   hits;
   logic [FW-1:0]          hit_full;
   logic [WAW-1:0]         next_word;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - POS_OUT_W - 1){1'b0}}, rsp_pos_ff, rsp_present_ff};

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign word         = rd_valid_ff ? rd_data_ff : '0;
   assign cur_full     = FW'(cur_ff);
   assign idx_full     = FW'(idx_ff);
   assign req_full     = FW'(req_tdata[INDEX_W-1:0]);
   assign idx_in_range = (32'(idx_ff) < CAPACITY);
   assign req_in_range = (32'(req_tdata[INDEX_W-1:0]) < CAPACITY);
   assign le_mask      = {WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - cur_full[BIT_W-1:0]);
   assign hits         = word & scan_mask;
   assign hit_full     = {scan_word_ff, lowest_set(hits)};
   assign next_word    = (scan_word_ff == LAST_WORD) ? '0 : scan_word_ff + 1'b1;

   always_comb begin
      if (scan_cnt_ff == '0) begin
         scan_mask = ~le_mask;
      end else if (scan_cnt_ff == LAST_STEP) begin
         scan_mask = le_mask;
      end else begin
         scan_mask = {WORD_BITS{1'b1}};
      end
   end

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      idx_in         = idx_ff;
      cur_in         = cur_ff;
      scan_word_in   = scan_word_ff;
      scan_cnt_in    = scan_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_present_in = rsp_present_ff;
      rsp_pos_in     = rsp_pos_ff;
      rd_en          = 1'b0;
      rd_addr        = '0;
      wr_en          = 1'b0;
      wr_addr        = idx_full[FW-1:BIT_W];
      wr_data        = word | ({{(WORD_BITS - 1){1'b0}}, 1'b1} << idx_full[BIT_W-1:0]);
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in = req_kind_type'(req_tuser);
               idx_in  = req_tdata[INDEX_W-1:0];
               rd_en   = 1'b1;
               if (req_kind_type'(req_tuser) == REQ_NEXT) begin
                  rd_addr      = cur_full[FW-1:BIT_W];
                  scan_word_in = cur_full[FW-1:BIT_W];
                  scan_cnt_in  = '0;
                  state_in     = S_SCAN;
               end else begin
                  rd_addr  = req_in_range ? req_full[FW-1:BIT_W] : '0;
                  state_in = S_ACC;
               end
            end
         end
         S_ACC: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_present_in = 1'b0;
               rsp_pos_in     = POS_OUT_W'(cur_ff);
               case (kind_ff)
                  REQ_ADD: begin
                     if (idx_in_range) begin
                        wr_en          = 1'b1;
                        cur_in         = PW'(idx_ff);
                        rsp_present_in = 1'b1;
                        rsp_pos_in     = POS_OUT_W'(idx_ff);
                     end
                  end
                  REQ_QUERY: begin
                     rsp_present_in = idx_in_range && word[idx_full[BIT_W-1:0]];
                  end
                  default: begin
                     rsp_present_in = 1'b0;
                  end
               endcase
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (hits != '0 || scan_cnt_ff == LAST_STEP) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  if (hits != '0) begin
                     cur_in         = PW'(hit_full);
                     rsp_present_in = 1'b1;
                     rsp_pos_in     = POS_OUT_W'(hit_full);
                  end else begin
                     rsp_present_in = 1'b0;
                     rsp_pos_in     = POS_OUT_W'(cur_ff);
                  end
                  state_in = S_IDLE;
               end
            end else begin
               rd_en        = 1'b1;
               rd_addr      = next_word;
               scan_word_in = next_word;
               scan_cnt_in  = scan_cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         scan_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_cnt_ff  <= scan_cnt_in;
      end
      kind_ff        <= kind_in;
      idx_ff         <= idx_in;
      scan_word_ff   <= scan_word_in;
      rsp_present_ff <= rsp_present_in;
      rsp_pos_ff     <= rsp_pos_in;
   end

   // bitmap word memory, one read and one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wvalid_ff   <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            wvalid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= wvalid_ff[rd_addr];
         end
      end
   end

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !wr_en)
      else $error("bitmap written while idle");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(cur_ff) < CAPACITY)
      else $error("current position beyond capacity");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (scan_cnt_ff <= LAST_STEP))
      else $error("scan ran past the last word");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second beat taken while one is in flight");

   a_scan_done_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && state_in == S_IDLE) |=> rsp_valid_ff)
      else $error("scan finished without a result");

endmodule

`default_nettype wire

### tb/sv/tb.sv
// testbench for the circular bitmap block: directed and random requests checked against a predictor
`default_nettype none

module tb;
   import bscn_pkg::*;

   localparam int SLOTS       = CAPACITY_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_START  = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_REQS = 1800;

   typedef struct {
      req_kind_type           kind;
      logic [INDEX_W-1:0]     index;
   } bitmap_req_type;

   typedef struct {
      logic                   present;
      logic [POS_OUT_W-1:0]   position;
   } bitmap_rsp_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;  // [9:0] index, rest zero
   logic [1:0]             req_tuser = '0;  // [1:0] req_type
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;       // [0] present, [9:1] position, rest zero

   bitmap_req_type pending_req[$];
   bitmap_rsp_type expected_rsp[$];
   int unsigned added_idx[$];

   bit [SLOTS-1:0] member_map = '0;
   int             cur_pos    = 0;
   int             errors     = 0;
   int             cycle_count = 0;
   int             burst_left = 1;
   int             gap_left   = 0;
   int             rx_cycles  = 0;
   int             hold_left  = 0;
   int             phase_cnt  = 0;
   int             phase_len  = 50;
   int             stall_kind = 0;

   bitmap_set_circular_next dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int wrap_pos(input int p);
      return (p + 1 >= SLOTS) ? 0 : p + 1;
   endfunction

   // advance the bitmap state by one request and queue the result it gives
   function automatic void step_bitmap(input req_kind_type kind, input logic [INDEX_W-1:0] idx);
      bitmap_rsp_type r;
      int             p;
      r.present = 1'b0;
      case (kind)
         REQ_ADD: begin
            if (idx < SLOTS) begin
               member_map[idx] = 1'b1;
               cur_pos = idx;
               r.present = 1'b1;
            end
         end
         REQ_QUERY: begin
            if (idx < SLOTS) r.present = member_map[idx];
         end
         REQ_NEXT: begin
            p = wrap_pos(cur_pos);
            while (p != cur_pos && !member_map[p]) p = wrap_pos(p);
            cur_pos = p;
            r.present = member_map[p];
         end
         default: ;
      endcase
      r.position = POS_OUT_W'(cur_pos);
      expected_rsp.push_back(r);
   endfunction

   task automatic push_req(input req_kind_type kind, input int idx);
      bitmap_req_type q;
      q.kind = kind;
      q.index = INDEX_W'(idx);
      pending_req.push_back(q);
      if (kind == REQ_ADD && idx < SLOTS) added_idx.push_back(idx);
   endtask

   initial begin
      int unsigned  roll;
      int           add_pct;
      int           idx;
      req_kind_type kind;

      // directed
      push_req(REQ_NEXT, 0);
      push_req(REQ_QUERY, 0);
      push_req(REQ_ADD, 7);
      push_req(REQ_NEXT, 0);
      push_req(REQ_ADD, 0);
      push_req(REQ_ADD, 511);
      push_req(REQ_NEXT, 1023);
      push_req(REQ_NEXT, 0);
      push_req(REQ_NEXT, 0);
      push_req(REQ_ADD, 512);
      push_req(REQ_ADD, 1023);
      push_req(REQ_QUERY, 512);
      push_req(REQ_QUERY, 1023);
      push_req(REQ_QUERY, 511);
      push_req(REQ_QUERY, 6);
      push_req(REQ_NONE, 1023);
      push_req(REQ_NONE, 0);
      push_req(REQ_ADD, 64);
      push_req(REQ_ADD, 63);
      push_req(REQ_NEXT, 0);
      push_req(REQ_NEXT, 0);
      push_req(REQ_ADD, 341);
      push_req(REQ_ADD, 170);
      push_req(REQ_QUERY, 341);

      // random, sparse bitmap first so next scans cross many words
      for (int i = 0; i < RANDOM_REQS; i++) begin
         add_pct = (i < 700) ? 4 : 14;
         roll = $urandom_range(0, 99);
         if (roll < add_pct) begin
            kind = REQ_ADD;
            idx = ($urandom_range(0, 6) == 0) ? $urandom_range(SLOTS, 1023)
                                              : $urandom_range(0, SLOTS - 1);
         end else if (roll < 45) begin
            kind = REQ_QUERY;
            if (added_idx.size() != 0 && $urandom_range(0, 1) == 0)
               idx = added_idx[$urandom_range(0, added_idx.size() - 1)];
            else
               idx = $urandom_range(0, 1023);
         end else if (roll < 95) begin
            kind = REQ_NEXT;
            idx = $urandom_range(0, 1023);
         end else begin
            kind = REQ_NONE;
            idx = $urandom_range(0, 1023);
         end
         push_req(kind, idx);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_req.size() != 0 || req_tvalid || expected_rsp.size() != 0)
         @(negedge clock);
      repeat (30) @(posedge clock);

      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // sender: bursts of beats with random gaps
   always @(posedge clock) begin : driver
      bitmap_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = $urandom_range(1, 16);
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready)
            step_bitmap(req_kind_type'(req_tuser), req_tdata[INDEX_W-1:0]);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0 || pending_req.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               nxt = pending_req.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= REQ_TDATA_W'(nxt.index);
               req_tuser <= nxt.kind;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end
            end
         end
      end
   end

   // receiver: changing stall patterns plus one long hold-off
   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_cycles++;
         if (rx_cycles == HOLD_START) hold_left = HOLD_CYCLES;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            phase_cnt++;
            if (phase_cnt >= phase_len) begin
               phase_cnt = 0;
               phase_len = $urandom_range(20, 200);
               stall_kind = $urandom_range(0, 3);
            end
            case (stall_kind)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= ((phase_cnt % 7) < 2);
               default: rsp_tready <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   always @(posedge clock) begin : monitor
      bitmap_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp.size() == 0) begin
            $error("result beat with nothing expected: tdata %h", rsp_tdata);
            errors++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_tdata[0] !== want.present) begin
               $error("present: expected %0d, actual %0d", want.present, rsp_tdata[0]);
               errors++;
            end
            if (rsp_tdata[POS_OUT_W:1] !== want.position) begin
               $error("position: expected %0d, actual %0d", want.position,
                      rsp_tdata[POS_OUT_W:1]);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule

`default_nettype wire
